FILE: src/text_integer_field_scanner_macros.svh
// Assertion helpers shared by the scanner modules.
`ifndef TEXT_INTEGER_FIELD_SCANNER_MACROS_SVH
`define TEXT_INTEGER_FIELD_SCANNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TIFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TIFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tifs_pkg.sv
package tifs_pkg;

    localparam int V_BITS  = 32;
    localparam int W_BITS  = 8;
    localparam int W_MAX   = (1 << W_BITS) - 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR   = $clog2(Q_DEPTH);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_NUMBER_BASE   = 2'd0;
    localparam logic [1:0] REG_UNSIGNED_MODE = 2'd1;
    localparam logic [1:0] REG_SIZE_MODE     = 2'd2;
    localparam logic [1:0] REG_MAX_WIDTH     = 2'd3;

    localparam logic [1:0] SIZE_SHORT = 2'd0;
    localparam logic [1:0] SIZE_INT   = 2'd1;
    localparam logic [1:0] SIZE_LONG  = 2'd2;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] UP_BIAS   = CH_UP_A - 8'd10;
    localparam logic [7:0] LOW_BIAS  = CH_LOW_A - 8'd10;

    typedef struct packed {
        logic [5:0] number_base;
        logic       unsigned_mode;
        logic [1:0] size_mode;
        logic [7:0] max_width;
    } t_cfg;

    // One classified character beat.
    typedef struct packed {
        logic       eoi;
        logic       is_space;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic       is_alnum;
        logic [5:0] digit;
    } t_cls;

    // A finished field before range checks.
    typedef struct packed {
        logic [V_BITS-1:0] acc;
        logic              neg;
        logic              seen;
        logic              taken;
        logic              at_end;
    } t_raw;

endpackage

FILE: src/tifs_front.sv
module tifs_front
    import tifs_pkg::*;
(
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [7:0] ch;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cls          = '0;
        o_cls.eoi      = s_axis_tlast;
        o_cls.is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        o_cls.is_minus = (ch == CH_MINUS);
        o_cls.is_plus  = (ch == CH_PLUS);
        o_cls.is_zero  = (ch == CH_ZERO);
        o_cls.is_x     = (ch == CH_LOW_X) || (ch == CH_UP_X);
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            o_cls.is_alnum = 1'b1;
            o_cls.digit    = 6'(ch - CH_ZERO);
        end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
            o_cls.is_alnum = 1'b1;
            o_cls.digit    = 6'(ch - UP_BIAS);
        end else if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
            o_cls.is_alnum = 1'b1;
            o_cls.digit    = 6'(ch - LOW_BIAS);
        end
    end

endmodule

FILE: src/tifs_queue.sv
`include "text_integer_field_scanner_macros.svh"

module tifs_queue
    import tifs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_full,
    output logic o_valid,
    output t_cls o_cls,
    input  logic i_pop
);

    t_cls             r_mem [Q_DEPTH];
    logic [Q_PTR-1:0] r_wr;
    logic [Q_PTR-1:0] r_rd;
    logic [Q_PTR:0]   r_count;

    assign o_full  = (r_count == (Q_PTR+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TIFS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= (Q_PTR+1)'(Q_DEPTH), "queue count beyond depth")
    `TIFS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "queue popped while empty")
    `TIFS_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !i_push, r_count == $past(r_count) - 1'b1, "queue count did not drop on pop")

endmodule

FILE: src/tifs_back.sv
`include "text_integer_field_scanner_macros.svh"

module tifs_back
    import tifs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_cls i_cls,
    output logic o_pop,
    output logic o_raw_valid,
    output t_raw o_raw,
    input  logic i_raw_ready
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_XCHK,
        PH_DIGIT
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [V_BITS-1:0] r_acc, n_acc;
    logic [5:0]        r_base, n_base;
    logic              r_neg, n_neg;
    logic              r_seen, n_seen;
    logic [W_BITS-1:0] r_wl, n_wl;
    logic              r_capped, n_capped;
    logic              r_raw_valid;
    t_raw              r_raw;

    logic              go;
    logic              fin;
    logic              taken;
    logic              at_end;
    logic              start;
    t_phase            ph;
    logic [5:0]        base_cur;
    logic [5:0]        base_d;
    logic              capped_cur;
    logic [W_BITS-1:0] wl_init;
    logic [W_BITS-1:0] wl_cur;
    logic [W_BITS-1:0] wl_dec;
    logic              room;
    logic              check;
    logic              zero_path;
    logic              xchk_path;
    logic              digit_path;

    assign go          = i_q_valid && (!r_raw_valid || i_raw_ready);
    assign o_pop       = go;
    assign o_raw_valid = r_raw_valid;
    assign o_raw       = r_raw;
    assign wl_init     = (int'(i_cfg.max_width) > W_MAX) ? W_BITS'(W_MAX)
                                                         : W_BITS'(i_cfg.max_width);

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_base     = r_base;
        n_neg      = r_neg;
        n_seen     = r_seen;
        n_wl       = r_wl;
        n_capped   = r_capped;
        fin        = 1'b0;
        taken      = 1'b0;
        at_end     = 1'b0;
        start      = (r_phase == PH_SKIP);
        ph         = start ? PH_SIGN : r_phase;
        base_cur   = start ? i_cfg.number_base : r_base;
        capped_cur = start ? (i_cfg.max_width != '0) : r_capped;
        wl_cur     = start ? wl_init : r_wl;
        wl_dec     = capped_cur ? wl_cur - 1'b1 : wl_cur;
        room       = !capped_cur || (wl_dec != '0);
        base_d     = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
        check      = 1'b0;
        zero_path  = 1'b0;
        xchk_path  = 1'b0;
        digit_path = 1'b0;

        if (go) begin
            if (i_cls.eoi) begin
                fin    = 1'b1;
                at_end = 1'b1;
            end else if (!(start && i_cls.is_space)) begin
                n_base   = base_cur;
                n_capped = capped_cur;
                n_wl     = wl_dec;
                case (ph)
                    PH_SIGN: begin
                        n_phase = PH_ZERO;
                        if (i_cls.is_minus) begin
                            n_neg = 1'b1;
                            check = 1'b1;
                        end else if (i_cls.is_plus) begin
                            check = 1'b1;
                        end else begin
                            zero_path = 1'b1;
                        end
                    end
                    PH_ZERO:  zero_path  = 1'b1;
                    PH_XCHK:  xchk_path  = 1'b1;
                    PH_DIGIT: digit_path = 1'b1;
                    default:  digit_path = 1'b1;
                endcase

                // A leading zero counts as a number even if no digit follows.
                if (zero_path) begin
                    n_phase = PH_DIGIT;
                    if (i_cls.is_zero) begin
                        n_seen = 1'b1;
                        check  = 1'b1;
                        if (room) begin
                            if (base_cur == BASE_AUTO) begin
                                n_base  = BASE_OCT;
                                n_phase = PH_XCHK;
                            end else if (base_cur == BASE_HEX) begin
                                n_phase = PH_XCHK;
                            end
                        end
                    end else begin
                        digit_path = 1'b1;
                    end
                end

                // After 0x a hex digit must follow before the field is valid.
                if (xchk_path) begin
                    n_phase = PH_DIGIT;
                    if (i_cls.is_x) begin
                        n_base = BASE_HEX;
                        n_seen = 1'b0;
                        check  = 1'b1;
                    end else begin
                        digit_path = 1'b1;
                    end
                end

                if (digit_path) begin
                    if (!i_cls.is_alnum || (i_cls.digit >= base_d)) begin
                        fin = 1'b1;
                    end else begin
                        n_base = base_d;
                        n_acc  = V_BITS'(r_acc * V_BITS'(base_d)) + V_BITS'(i_cls.digit);
                        n_seen = 1'b1;
                        check  = 1'b1;
                    end
                end

                if (check && capped_cur && (wl_dec == '0)) begin
                    fin   = 1'b1;
                    taken = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_acc       <= '0;
            r_base      <= BASE_DEC;
            r_neg       <= 1'b0;
            r_seen      <= 1'b0;
            r_wl        <= '0;
            r_capped    <= 1'b0;
            r_raw_valid <= 1'b0;
        end else begin
            r_base   <= n_base;
            r_wl     <= n_wl;
            r_capped <= n_capped;
            if (fin) begin
                r_phase <= PH_SKIP;
                r_acc   <= '0;
                r_neg   <= 1'b0;
                r_seen  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_seen  <= n_seen;
            end
            if (fin) begin
                r_raw_valid <= 1'b1;
            end else if (i_raw_ready) begin
                r_raw_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_raw.acc    <= n_acc;
            r_raw.neg    <= n_neg;
            r_raw.seen   <= n_seen;
            r_raw.taken  <= taken;
            r_raw.at_end <= at_end;
        end
    end

    `TIFS_ASSERT_IMP(a_skip_clean, i_clk, i_rst_n, r_phase == PH_SKIP, (r_acc == '0) && !r_neg && !r_seen, "field state not cleared while skipping")
    `TIFS_ASSERT_IMP(a_xchk_base, i_clk, i_rst_n, r_phase == PH_XCHK, (r_base == BASE_OCT) || (r_base == BASE_HEX), "prefix check with a base other than 8 or 16")
    `TIFS_ASSERT_NEXT(a_raw_hold, i_clk, i_rst_n, r_raw_valid && !i_raw_ready, r_raw_valid && $stable(r_raw), "pending field result lost or changed")

endmodule

FILE: src/tifs_format.sv
module tifs_format
    import tifs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_raw_valid,
    input  t_raw        i_raw,
    output logic        o_raw_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic              r_valid;
    logic [V_BITS-1:0] r_value;
    logic              r_matched;
    logic              r_ovf;
    logic              r_taken;
    logic              r_end;

    logic              uns;
    logic              s16;
    logic              negate;
    logic [V_BITS-1:0] rv;
    logic              ovf;
    logic              fits16;
    logic [V_BITS-1:0] sat;
    logic [V_BITS-1:0] res;

    assign o_raw_ready   = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'b0, r_taken, r_ovf, r_matched, r_value};
    assign m_axis_tlast  = r_end;

    always_comb begin
        uns    = i_cfg.unsigned_mode;
        s16    = (i_cfg.size_mode == SIZE_SHORT);
        negate = i_raw.neg && (i_raw.acc != '0);
        rv     = negate ? V_BITS'(-i_raw.acc) : i_raw.acc;
        if (negate) begin
            // A negated nonzero value that comes out positive wrapped around.
            ovf = uns || !rv[V_BITS-1];
        end else begin
            ovf = !uns && rv[V_BITS-1];
        end
        if (uns) begin
            fits16 = (rv[V_BITS-1:16] == '0);
        end else begin
            fits16 = (rv[V_BITS-1:15] == '0) || (&rv[V_BITS-1:15]);
        end
        if (s16 && !fits16) begin
            ovf = 1'b1;
        end
        if (uns) begin
            sat = '0;
        end else if (s16) begin
            sat = V_BITS'(32'h0000_8000);
        end else begin
            sat = {1'b1, {(V_BITS-1){1'b0}}};
        end
        if (!i_raw.neg) begin
            sat = ~sat;
        end
        res = ovf ? sat : rv;
        if (s16) begin
            res = {{(V_BITS-16){1'b0}}, res[15:0]};
        end
        if (!i_raw.seen) begin
            res = '0;
            ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_raw_valid && o_raw_ready) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_raw_valid && o_raw_ready) begin
            r_value   <= res;
            r_matched <= i_raw.seen;
            r_ovf     <= ovf;
            r_taken   <= i_raw.taken;
            r_end     <= i_raw.at_end;
        end
    end

endmodule

FILE: src/text_integer_field_scanner.sv
// Integer field scanner: turns a stream of text bytes into converted numbers.
// Input channel (s_axis): one beat per text byte in tdata; a beat with tlast
// high marks end of text and its tdata is ignored. Leading whitespace is
// skipped, then an optional sign, an optional 0 / 0x prefix and digits.
// Output channel (m_axis): one beat per field with the value, matched,
// overflow and char_taken flags; tlast is high when the field ended at end
// of text. A char_taken of 0 means the last byte was not part of the field;
// the feeder presents it again if it should start the next field.
// Configuration: write number_base, unsigned_mode, size_mode and max_width
// through i_cfg_we / i_cfg_addr / i_cfg_wdata while no field is in flight.
// Throughput: one input beat per cycle while the input queue is not full; the
// digit multiply-add by the base is done once per byte in the scan engine.
// The beat ending a field passes through the input queue, then the scan
// engine's result register; the range check feeds the output register.
// Reset (synchronous, active low) empties the queue, drops any partial field
// and loads base 10, signed, int size and no width limit.
// When the receiver holds tready low, results wait in the output and engine
// registers and the four-entry input queue keeps taking bytes until full.
module text_integer_field_scanner
    import tifs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tlast,  // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] value, [32] matched, [33] overflow,
                                       // [34] char_taken, [39:35] zero
    output logic        m_axis_tlast   // hit_end
);

    t_cfg r_cfg;

    logic q_full;
    logic push;
    t_cls push_cls;
    logic q_valid;
    t_cls q_cls;
    logic pop;
    logic raw_valid;
    t_raw raw;
    logic raw_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base   <= BASE_DEC;
            r_cfg.unsigned_mode <= 1'b0;
            r_cfg.size_mode     <= SIZE_INT;
            r_cfg.max_width     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_NUMBER_BASE:   r_cfg.number_base   <= i_cfg_wdata[5:0];
                REG_UNSIGNED_MODE: r_cfg.unsigned_mode <= i_cfg_wdata[0];
                REG_SIZE_MODE:     r_cfg.size_mode     <= i_cfg_wdata[1:0];
                REG_MAX_WIDTH:     r_cfg.max_width     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    tifs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cls         (push_cls)
    );

    tifs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (push_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .i_pop   (pop)
    );

    tifs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_cls       (q_cls),
        .o_pop       (pop),
        .o_raw_valid (raw_valid),
        .o_raw       (raw),
        .i_raw_ready (raw_ready)
    );

    tifs_format u_format (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_raw_valid   (raw_valid),
        .i_raw         (raw),
        .o_raw_ready   (raw_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
